@@ hdl/lfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// LED frame stream parser package
// Shared types, event codes and protocol constants of the frame parser.
// ----------------------------------------------------------------------------
package lfsp_pkg;

    localparam int unsigned LED_CAPACITY = 300;

    localparam logic [7:0]  SYNC_A        = 8'h41;
    localparam logic [7:0]  SYNC_D        = 8'h64;
    localparam logic [7:0]  SYNC_LA       = 8'h61;
    localparam logic [7:0]  CHECK_MASK    = 8'h55;
    localparam logic [15:0] TIMEOUT_RESET = 16'd8000;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [10:0] CAPACITY_CNT  = 11'(LED_CAPACITY);
    localparam logic [16:0] CAPACITY_LEN  = 17'(LED_CAPACITY);

    localparam logic        OP_BYTE = 1'b0;
    localparam logic        OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        EV_CLEAR = 2'd0,
        EV_PIXEL = 2'd1,
        EV_SHOW  = 2'd2,
        EV_BLANK = 2'd3
    } event_t;

    typedef enum logic [3:0] {
        PH_A     = 4'd0,
        PH_D     = 4'd1,
        PH_LA    = 4'd2,
        PH_HIGH  = 4'd3,
        PH_LOW   = 4'd4,
        PH_CHECK = 4'd5,
        PH_RED   = 4'd6,
        PH_GREEN = 4'd7,
        PH_BLUE  = 4'd8
    } phase_t;

    typedef struct packed {
        event_t      event_kind;
        logic [9:0]  pixel_index;
        logic [10:0] pixel_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic result_t make_result(
        input event_t      kind,
        input logic [9:0]  idx,
        input logic [10:0] cnt,
        input logic [7:0]  r,
        input logic [7:0]  g,
        input logic [7:0]  b,
        input logic        fin
    );
        result_t res;
        res.event_kind  = kind;
        res.pixel_index = idx;
        res.pixel_count = cnt;
        res.red         = r;
        res.green       = g;
        res.blue        = b;
        res.last        = fin;
        return res;
    endfunction

endpackage

@@ hdl/led_frame_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// LED frame stream parser
// Parses an Adalight-style serial stream into clear, pixel, show and blank
// events, with an idle timeout counted in millisecond ticks.
// ----------------------------------------------------------------------------
// One input beat is taken every cycle as long as the result queue holds at
// most two results; an accepted input beat is registered ahead of the
// parser, and its results are registered in the result queue before they
// leave. The output side moves one result per cycle while out_stall is low,
// so the final blue byte of a frame, which yields a pixel write and a show,
// costs two output beats and sets the sustained rate when frames are short.
module led_frame_stream_parser_unit
    import lfsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [9:0]  pixel_index,
    output logic [10:0] pixel_count,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last
);

    logic         stage_valid_reg, stage_valid_next;
    logic         opcode_reg;
    logic [7:0]   byte_reg;
    logic         has_room;
    logic         fire;
    logic         accept;
    result_pair_t results;
    result_t      head;

    assign fire     = stage_valid_reg && has_room;
    assign in_stall = stage_valid_reg && !has_room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (fire)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= opcode;
            byte_reg   <= data_byte;
        end
    end

    lfsp_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .fire             (fire),
        .opcode           (opcode_reg),
        .data_byte        (byte_reg),
        .results          (results)
    );

    lfsp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (results),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign event_kind  = head.event_kind;
    assign pixel_index = head.pixel_index;
    assign pixel_count = head.pixel_count;
    assign red         = head.red;
    assign green       = head.green;
    assign blue        = head.blue;
    assign last        = head.last;

endmodule

@@ hdl/lfsp_parser.sv @@
// ----------------------------------------------------------------------------
// LED frame parser core
// Holds the parse state and the idle counter and turns one registered beat
// into zero, one or two result items.
// ----------------------------------------------------------------------------
module lfsp_parser
    import lfsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_enable,
    input  logic [15:0]  cfg_write_data,
    input  logic         fire,
    input  logic         opcode,
    input  logic [7:0]   data_byte,
    output result_pair_t results
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  low_reg, low_next;
    logic [10:0] length_reg, length_next;
    logic [9:0]  pixel_reg, pixel_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] timeout_reg;

    logic [16:0] header_len;
    logic [10:0] capped_len;
    logic [10:0] pixel_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_A;
            high_reg    <= '0;
            low_reg     <= '0;
            length_reg  <= '0;
            pixel_reg   <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            idle_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            length_reg <= length_next;
            pixel_reg  <= pixel_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            idle_reg   <= idle_next;
            if (cfg_write_enable)
            begin
                timeout_reg <= cfg_write_data;
            end
        end
    end

    assign header_len = {1'b0, high_reg, low_reg} + 17'd1;
    assign capped_len = (header_len > CAPACITY_LEN) ? CAPACITY_CNT : header_len[10:0];
    assign pixel_plus = {1'b0, pixel_reg} + 11'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        length_next = length_reg;
        pixel_next  = pixel_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        idle_next   = idle_reg;
        results     = '0;

        if (fire)
        begin
            if (opcode == OP_TICK)
            begin
                if ((timeout_reg != '0) && (idle_reg >= timeout_reg))
                begin
                    results.num   = 2'd1;
                    results.first = make_result(EV_BLANK, '0, CAPACITY_CNT,
                                                '0, '0, '0, 1'b1);
                    idle_next     = '0;
                    phase_next    = PH_A;
                end
                else if (idle_reg != IDLE_MAX)
                begin
                    idle_next = idle_reg + 16'd1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_D:
                    begin
                        if (data_byte == SYNC_D)
                            phase_next = PH_LA;
                        else
                            phase_next = (data_byte == SYNC_A) ? PH_D : PH_A;
                    end
                    PH_LA:
                    begin
                        if (data_byte == SYNC_LA)
                            phase_next = PH_HIGH;
                        else
                            phase_next = (data_byte == SYNC_A) ? PH_D : PH_A;
                    end
                    PH_HIGH:
                    begin
                        high_next  = data_byte;
                        phase_next = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        low_next   = data_byte;
                        phase_next = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        if (data_byte == (high_reg ^ low_reg ^ CHECK_MASK))
                        begin
                            length_next   = capped_len;
                            pixel_next    = '0;
                            results.num   = 2'd1;
                            results.first = make_result(EV_CLEAR, '0, capped_len,
                                                        '0, '0, '0, 1'b1);
                            phase_next    = PH_RED;
                        end
                        else
                        begin
                            phase_next = PH_A;
                        end
                    end
                    PH_RED:
                    begin
                        red_next   = data_byte;
                        phase_next = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        green_next = data_byte;
                        phase_next = PH_BLUE;
                    end
                    PH_BLUE:
                    begin
                        if (pixel_plus >= length_reg)
                        begin
                            results.num    = 2'd2;
                            results.first  = make_result(EV_PIXEL, pixel_reg, '0,
                                                         red_reg, green_reg,
                                                         data_byte, 1'b0);
                            results.second = make_result(EV_SHOW, '0, length_reg,
                                                         '0, '0, '0, 1'b1);
                            idle_next      = '0;
                            pixel_next     = '0;
                            phase_next     = PH_A;
                        end
                        else
                        begin
                            results.num   = 2'd1;
                            results.first = make_result(EV_PIXEL, pixel_reg, '0,
                                                        red_reg, green_reg,
                                                        data_byte, 1'b1);
                            pixel_next    = pixel_plus[9:0];
                            phase_next    = PH_RED;
                        end
                    end
                    default:
                    begin
                        phase_next = (data_byte == SYNC_A) ? PH_D : PH_A;
                    end
                endcase
            end
        end
    end

endmodule

@@ hdl/lfsp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// LED frame parser result queue
// Four-entry queue that takes up to two results per cycle and hands out one
// result beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module lfsp_out_fifo
    import lfsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_pair_t push,
    output logic         has_room,
    output logic         out_valid,
    input  logic         out_stall,
    output result_t      head
);

    result_t     entry_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;
    logic [1:0]  wr_ptr_plus;

    assign out_valid   = (count_reg != 3'd0);
    assign pop         = out_valid && !out_stall;
    assign has_room    = (count_reg <= 3'd2);
    assign head        = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus = wr_ptr_reg + 2'd1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.num;
        rd_ptr_next = pop ? (rd_ptr_reg + 2'd1) : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.num} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= push.second;
        end
    end

endmodule

@@ dv/tb_led_frame_stream_parser_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED frame stream parser testbench
// Drives serial bytes and millisecond ticks into the parser and checks every
// clear, pixel, show and blank beat against a cycle-free prediction of the
// protocol. Covers header sync, bad checks, capacity limits, full frames and
// the idle timeout at its reset value and at its extremes, and finishes with
// random traffic under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_led_frame_stream_parser_unit;
    import lfsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [15:0] cfg_write_data   = '0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic        opcode           = OP_BYTE;
    logic [7:0]  data_byte        = '0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic [1:0]  event_kind;
    logic [9:0]  pixel_index;
    logic [10:0] pixel_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned tick_in_frame_pct  = 0;
    int unsigned beats_sent         = 0;
    int unsigned error_count        = 0;
    int unsigned cycle_count        = 0;

    phase_t      phase_now   = PH_A;
    logic [7:0]  hi_byte     = '0;
    logic [7:0]  lo_byte     = '0;
    logic [10:0] frame_len   = '0;
    logic [9:0]  pixel_ptr   = '0;
    logic [7:0]  red_latch   = '0;
    logic [7:0]  green_latch = '0;
    logic [15:0] idle_ms     = '0;
    logic [15:0] timeout_ms  = TIMEOUT_RESET;

    result_t expected_events[$];

    led_frame_stream_parser_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_kind       (event_kind),
        .pixel_index      (pixel_index),
        .pixel_count      (pixel_count),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .last             (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic predict_events(input logic op, input logic [7:0] b);
        result_t     found[2];
        int unsigned n;
        logic [16:0] len;
        n = 0;
        if (op == OP_TICK)
        begin
            if (timeout_ms != 16'd0 && idle_ms >= timeout_ms)
            begin
                found[n] = '{event_kind: EV_BLANK, pixel_index: 10'd0,
                             pixel_count: CAPACITY_CNT, red: 8'd0, green: 8'd0,
                             blue: 8'd0, last: 1'b0};
                n++;
                idle_ms   = '0;
                phase_now = PH_A;
            end
            else if (idle_ms != IDLE_MAX)
            begin
                idle_ms++;
            end
        end
        else
        begin
            case (phase_now)
                PH_D:
                begin
                    if (b == SYNC_D)
                        phase_now = PH_LA;
                    else
                        phase_now = (b == SYNC_A) ? PH_D : PH_A;
                end
                PH_LA:
                begin
                    if (b == SYNC_LA)
                        phase_now = PH_HIGH;
                    else
                        phase_now = (b == SYNC_A) ? PH_D : PH_A;
                end
                PH_HIGH:
                begin
                    hi_byte   = b;
                    phase_now = PH_LOW;
                end
                PH_LOW:
                begin
                    lo_byte   = b;
                    phase_now = PH_CHECK;
                end
                PH_CHECK:
                begin
                    if (b == (hi_byte ^ lo_byte ^ CHECK_MASK))
                    begin
                        len = 17'({hi_byte, lo_byte}) + 17'd1;
                        if (len > CAPACITY_LEN)
                            len = CAPACITY_LEN;
                        frame_len = len[10:0];
                        pixel_ptr = '0;
                        found[n] = '{event_kind: EV_CLEAR, pixel_index: 10'd0,
                                     pixel_count: frame_len, red: 8'd0, green: 8'd0,
                                     blue: 8'd0, last: 1'b0};
                        n++;
                        phase_now = PH_RED;
                    end
                    else
                    begin
                        phase_now = PH_A;
                    end
                end
                PH_RED:
                begin
                    red_latch = b;
                    phase_now = PH_GREEN;
                end
                PH_GREEN:
                begin
                    green_latch = b;
                    phase_now   = PH_BLUE;
                end
                PH_BLUE:
                begin
                    found[n] = '{event_kind: EV_PIXEL, pixel_index: pixel_ptr,
                                 pixel_count: 11'd0, red: red_latch, green: green_latch,
                                 blue: b, last: 1'b0};
                    n++;
                    if (11'(pixel_ptr) + 11'd1 >= frame_len)
                    begin
                        found[n] = '{event_kind: EV_SHOW, pixel_index: 10'd0,
                                     pixel_count: frame_len, red: 8'd0, green: 8'd0,
                                     blue: 8'd0, last: 1'b0};
                        n++;
                        idle_ms   = '0;
                        pixel_ptr = '0;
                        phase_now = PH_A;
                    end
                    else
                    begin
                        pixel_ptr++;
                        phase_now = PH_RED;
                    end
                end
                default:
                begin
                    phase_now = (b == SYNC_A) ? PH_D : PH_A;
                end
            endcase
        end
        if (n > 0)
            found[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events.push_back(found[i]);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected result beat: event_kind %0d, pixel_index %0d",
                       event_kind, pixel_index);
                error_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_kind !== want.event_kind)
                begin
                    $error("event_kind: expected %0d, actual %0d", want.event_kind, event_kind);
                    error_count++;
                end
                if (pixel_index !== want.pixel_index)
                begin
                    $error("pixel_index: expected %0d, actual %0d", want.pixel_index, pixel_index);
                    error_count++;
                end
                if (pixel_count !== want.pixel_count)
                begin
                    $error("pixel_count: expected %0d, actual %0d", want.pixel_count, pixel_count);
                    error_count++;
                end
                if (red !== want.red)
                begin
                    $error("red: expected %0d, actual %0d", want.red, red);
                    error_count++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %0d, actual %0d", want.green, green);
                    error_count++;
                end
                if (blue !== want.blue)
                begin
                    $error("blue: expected %0d, actual %0d", want.blue, blue);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_events(op, b);
        beats_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        timeout_ms = value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_beat(OP_TICK, 8'($urandom));
    endtask

    task automatic send_header(input logic [7:0] hi, input logic [7:0] lo, input logic good);
        logic [7:0] check;
        check = hi ^ lo ^ CHECK_MASK;
        if (!good)
            check = check ^ 8'($urandom_range(1, 255));
        send_beat(OP_BYTE, SYNC_A);
        send_beat(OP_BYTE, SYNC_D);
        send_beat(OP_BYTE, SYNC_LA);
        send_beat(OP_BYTE, hi);
        send_beat(OP_BYTE, lo);
        send_beat(OP_BYTE, check);
    endtask

    task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
                              input int unsigned triples);
        send_header(hi, lo, 1'b1);
        repeat (triples)
        begin
            if ($urandom_range(99) < tick_in_frame_pct)
                send_beat(OP_TICK, 8'($urandom));
            repeat (3) send_beat(OP_BYTE, 8'($urandom));
        end
    endtask

    task automatic test_reset_timeout();
        // A few idle ticks under the reset timeout of 8000 ms do not blank.
        send_ticks(3);
        send_beat(OP_TICK, 8'hFF);
    endtask

    task automatic test_header_sync();
        write_timeout(16'd2);
        // A repeated first header byte still synchronizes.
        send_beat(OP_BYTE, SYNC_A);
        send_header(8'h00, 8'h00, 1'b1);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        // A mismatching 'A' in the third header position restarts the match.
        send_beat(OP_BYTE, SYNC_A);
        send_beat(OP_BYTE, SYNC_D);
        send_header(8'hFF, 8'hFF, 1'b1);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'h00);
        // The third tick after the last show blanks and abandons the frame.
        send_beat(OP_TICK, 8'hFF);
        send_beat(OP_TICK, 8'h00);
        send_beat(OP_TICK, 8'hA5);
        send_header(8'h12, 8'h34, 1'b0);
    endtask

    task automatic test_timeout_limits();
        // With the timeout disabled, ticks only count.
        write_timeout(16'd0);
        send_ticks(6);
        write_timeout(16'hFFFF);
        send_ticks(2);
        write_timeout(16'd1);
        send_ticks(3);
    endtask

    task automatic test_capacity_limit();
        write_timeout(16'd2);
        // A count of 0x012B plus one is exactly capacity.
        send_frame(8'h01, 8'h2B, 3);
        send_ticks(3);
        // The largest count also saturates at capacity.
        send_header(8'hFF, 8'hFF, 1'b1);
        send_ticks(3);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input logic [15:0] timeout, input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        write_timeout(timeout);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        tick_in_frame_pct  = 5;
        stop_at = beats_sent + n_items;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                len = ($urandom_range(99) < 85) ? $urandom_range(0, 5) : $urandom_range(6, 40);
                send_frame(8'h00, 8'(len), len + 1);
            end
            else if (pick < 70 && timeout_ms != 16'd0 && timeout_ms <= 16'd20)
            begin
                send_frame(8'($urandom_range(1, 255)), 8'($urandom), $urandom_range(0, 3));
                send_ticks(timeout_ms + 1);
            end
            else if (pick < 78)
            begin
                if ($urandom_range(1) == 0)
                begin
                    send_header(8'($urandom), 8'($urandom), 1'b0);
                end
                else
                begin
                    send_beat(OP_BYTE, SYNC_A);
                    if ($urandom_range(1) == 0)
                        send_beat(OP_BYTE, SYNC_D);
                    send_beat(OP_BYTE, 8'($urandom));
                end
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 4)) send_beat(OP_BYTE, 8'($urandom));
            end
            else if (pick < 96)
            begin
                send_ticks($urandom_range(1, 3));
            end
            else
            begin
                wait_for_results();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_timeout();
        test_header_sync();
        test_timeout_limits();
        test_capacity_limit();
        test_random_traffic(0, 0, 16'd5, 95);
        test_random_traffic(66, 0, 16'd0, 95);
        test_random_traffic(0, 66, 16'd12, 95);
        test_random_traffic(37, 37, 16'd1, 95);
        wait_for_results();
        if (error_count == 0 && expected_events.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lfsp_pkg.sv
hdl/lfsp_parser.sv
hdl/lfsp_out_fifo.sv
hdl/led_frame_stream_parser_unit.sv
dv/tb_led_frame_stream_parser_unit.sv
